@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types for the LRU cache set: the decision that the way selector
// hands to the storage and response logic of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

   // Way numbers are carried at the width of the largest supported set.
   localparam int unsigned WAY_IDX_MAX_W = 5;

   typedef struct packed {
      logic                     hit;           // Block address matched a valid way.
      logic                     victim_valid;  // A miss displaces a valid line.
      logic [WAY_IDX_MAX_W-1:0] way;           // Way that is hit or filled.
   } way_decision_type;

endpackage

`default_nettype wire

@@ rtl/lcs_select.sv @@
// ----------------------------------------------------------------------------
// lcs_select
// Tag match across all ways, choice of the way to hit or fill (lowest empty
// way first, least recent way when the set is full) and the recency update.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_select #(
   parameter int unsigned WAYS   = 8,
   parameter int unsigned BLK_W  = 42,
   parameter int unsigned RANK_W = 3
) (
   input  logic [BLK_W-1:0]              blk,
   input  logic [WAYS-1:0]               valid,
   input  logic [BLK_W-1:0]              tags  [WAYS],
   input  logic [RANK_W-1:0]             ranks [WAYS],
   output lcs_pkg::way_decision_type     decision,
   output logic [RANK_W-1:0]             ranks_in [WAYS]
);
   import lcs_pkg::*;

   logic [RANK_W-1:0] hit_way;
   logic [RANK_W-1:0] empty_way;
   logic [RANK_W-1:0] lru_way;
   logic [RANK_W-1:0] sel_way;
   logic [RANK_W-1:0] sel_rank;
   logic              any_hit;
   logic              full;

   // Priority encoders: scanning from the top leaves the lowest match.
   always_comb begin
      hit_way   = '0;
      empty_way = '0;
      lru_way   = '0;
      any_hit   = 1'b0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid[i] && (tags[i] == blk)) begin
            hit_way = RANK_W'(i);
            any_hit = 1'b1;
         end
         if (!valid[i]) begin
            empty_way = RANK_W'(i);
         end
         // In a full set the ranks are a permutation, so the oldest way
         // holds the largest rank.
         if (ranks[i] == RANK_W'(WAYS - 1)) begin
            lru_way = RANK_W'(i);
         end
      end
   end

   assign full     = &valid;
   assign sel_way  = any_hit ? hit_way : (full ? lru_way : empty_way);
   assign sel_rank = ranks[sel_way];

   always_comb begin
      decision.hit          = any_hit;
      decision.victim_valid = !any_hit && full;
      decision.way          = WAY_IDX_MAX_W'(sel_way);
   end

   // On a hit only the ways more recent than the hit way age; on a fill every
   // other valid way ages by one.
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         if (RANK_W'(i) == sel_way) begin
            ranks_in[i] = '0;
         end else if (valid[i] && (!any_hit || (ranks[i] < sel_rank))) begin
            ranks_in[i] = ranks[i] + RANK_W'(1);
         end else begin
            ranks_in[i] = ranks[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/lru_cache_set_unit.sv @@
// ----------------------------------------------------------------------------
// lru_cache_set_unit
// One set of a set-associative write-back cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   An access item is taken at a rising edge where start is high and busy is
//   low. It carries a byte address, a write flag and a data word.
//   After the lookup stage, rsp_strobe is high for one cycle with the
//   result: hit, and on a miss into a full set the displaced line's block
//   address, dirty mark and data word (all zero when nothing is displaced).
//   A new item may be started every cycle while busy is low: tags, valid
//   and dirty marks and ranks sit in flip-flops and are updated in the lookup
//   cycle, and the data word memory is read and written in that same cycle,
//   so the next item's lookup already sees the result of the previous one.
//   busy is set while reset is high and clears at the first clock edge without reset.
//   Reset empties every way; tags, ranks and data are written before use.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_set_unit #(
   parameter int unsigned WAYS        = 8,
   parameter int unsigned OFFSET_BITS = 6,
   parameter int unsigned ADDR_BITS   = 48,
   parameter int unsigned DATA_BITS   = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ADDR_BITS-1:0]             req_byte_address,
   input  logic                             req_is_write,
   input  logic [DATA_BITS-1:0]             req_data_word,
   output logic                             rsp_strobe,
   output logic                             rsp_hit,
   output logic                             rsp_victim_valid,
   output logic [ADDR_BITS-OFFSET_BITS-1:0] rsp_victim_block_address,
   output logic                             rsp_victim_dirty,
   output logic [DATA_BITS-1:0]             rsp_victim_data
);
   import lcs_pkg::*;

   localparam int unsigned BLK_W  = ADDR_BITS - OFFSET_BITS;
   localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Lookup stage inputs.
   logic                 s1_valid_ff;
   logic [BLK_W-1:0]     s1_blk_ff;
   logic                 s1_wr_ff;
   logic [DATA_BITS-1:0] s1_data_ff;
   logic                 busy_ff;

   // Per-way state.
   logic [WAYS-1:0]      valid_ff;
   logic [WAYS-1:0]      dirty_ff;
   logic [BLK_W-1:0]     tag_ff  [WAYS];
   logic [RANK_W-1:0]    rank_ff [WAYS];
   logic [RANK_W-1:0]    rank_in [WAYS];
   logic [DATA_BITS-1:0] data_mem [WAYS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Response registers.
   logic                 rsp_strobe_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_victim_valid_ff;
   logic [BLK_W-1:0]     rsp_victim_blk_ff;
   logic                 rsp_victim_dirty_ff;

   way_decision_type     decision;
   logic [RANK_W-1:0]    way;
   logic                 accept;

   assign accept = start && !busy_ff;
   assign way    = decision.way[RANK_W-1:0];

   lcs_select #(
      .WAYS   (WAYS),
      .BLK_W  (BLK_W),
      .RANK_W (RANK_W)
   ) u_select (
      .blk      (s1_blk_ff),
      .valid    (valid_ff),
      .tags     (tag_ff),
      .ranks    (rank_ff),
      .decision (decision),
      .ranks_in (rank_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
         dirty_ff      <= '0;
      end else begin
         busy_ff       <= 1'b0;
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            valid_ff[way] <= 1'b1;
            if (decision.hit) begin
               dirty_ff[way] <= dirty_ff[way] | s1_wr_ff;
            end else begin
               dirty_ff[way] <= s1_wr_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_blk_ff  <= req_byte_address[ADDR_BITS-1:OFFSET_BITS];
         s1_wr_ff   <= req_is_write;
         s1_data_ff <= req_data_word;
      end
      if (s1_valid_ff) begin
         tag_ff[way] <= s1_blk_ff;
         rank_ff     <= rank_in;
         rsp_hit_ff          <= decision.hit;
         rsp_victim_valid_ff <= decision.victim_valid;
         rsp_victim_blk_ff   <= decision.victim_valid ? tag_ff[way] : '0;
         rsp_victim_dirty_ff <= decision.victim_valid & dirty_ff[way];
      end
   end

   // Read-before-write: a displaced line's word is read in the same cycle
   // that the new word lands at that way.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         data_mem[way] <= s1_data_ff;
         rd_data_ff    <= data_mem[way];
      end
   end

   assign busy                     = busy_ff;
   assign rsp_strobe               = rsp_strobe_ff;
   assign rsp_hit                  = rsp_hit_ff;
   assign rsp_victim_valid         = rsp_victim_valid_ff;
   assign rsp_victim_block_address = rsp_victim_blk_ff;
   assign rsp_victim_dirty         = rsp_victim_dirty_ff;
   assign rsp_victim_data          = rsp_victim_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/lcs_checker.sv @@
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks for the LRU cache set: result timing and the shape of
// each result item.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_checker #(
   parameter int unsigned WAYS        = 8,
   parameter int unsigned OFFSET_BITS = 6,
   parameter int unsigned ADDR_BITS   = 48,
   parameter int unsigned DATA_BITS   = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [ADDR_BITS-1:0]             req_byte_address,
   input  logic                             req_is_write,
   input  logic [DATA_BITS-1:0]             req_data_word,
   input  logic                             rsp_strobe,
   input  logic                             rsp_hit,
   input  logic                             rsp_victim_valid,
   input  logic [ADDR_BITS-OFFSET_BITS-1:0] rsp_victim_block_address,
   input  logic                             rsp_victim_dirty,
   input  logic [DATA_BITS-1:0]             rsp_victim_data
);

   // Every accepted item produces its result, after the lookup stage and the response register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   // No result appears without an accepted item that went through the lookup stage and the response register.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   // A hit never displaces a line.
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> !rsp_victim_valid)
      else $error("hit reported a victim");

   // Without a displaced line the victim fields read as zero.
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_victim_valid) |->
         (!rsp_victim_dirty && (rsp_victim_data == '0)
          && (rsp_victim_block_address == '0)))
      else $error("victim fields not zero without a victim");

   // The block does not take items while coming out of reset.
   a_busy_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("not busy right after reset");

endmodule

bind lru_cache_set_unit lcs_checker #(
   .WAYS        (WAYS),
   .OFFSET_BITS (OFFSET_BITS),
   .ADDR_BITS   (ADDR_BITS),
   .DATA_BITS   (DATA_BITS)
) u_lcs_checker (.*);

`default_nettype wire
